/* hdl/jpeg_dht_table_builder_assert.svh */
// assertion macros shared by the table builder modules
`ifndef JPEG_DHT_TABLE_BUILDER_ASSERT_SVH
`define JPEG_DHT_TABLE_BUILDER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// property must hold at every rising clock edge outside reset
`define JDTB_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("jdtb assertion failed");

// condition must never be seen outside reset
`define JDTB_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("jdtb forbidden condition seen");

`else

`define JDTB_ASSERT(lbl, clk, rst, prop)
`define JDTB_NEVER(lbl, clk, rst, cond)

`endif

`endif

/* hdl/jdtb_pkg.sv */
// types and constants shared by the table builder modules
`timescale 1ns / 1ps

package jdtb_pkg;

   localparam int MAX_CODES_DEF  = 256;
   localparam int NUM_TABLES_DEF = 8;
   localparam int QUEUE_DEPTH    = 4;
   localparam int NUM_COUNTS     = 16;
   localparam int DC_TABLES      = 4;
   localparam int AC_OFFSET      = 4;
   localparam int AC_BIT         = 4;
   localparam logic [7:0] ID_MASK = 8'h0f;

   typedef enum logic [2:0] {
      KIND_ENTRY     = 3'd0,
      KIND_TERM      = 3'd1,
      KIND_SYMBOL    = 3'd2,
      KIND_BAD_ID    = 3'd3,
      KIND_MANY      = 3'd4,
      KIND_TRUNC     = 3'd5
   } kind_type;

   typedef enum logic [3:0] {
      PH_HEADER  = 4'b0001,
      PH_COUNTS  = 4'b0010,
      PH_SYMBOLS = 4'b0100,
      PH_DROP    = 4'b1000
   } phase_type;

   typedef struct packed {
      kind_type    kind;
      logic [2:0]  table_index;
      logic [7:0]  slot;
      logic [15:0] first_code;
      logic [15:0] end_code;
      logic [4:0]  length_step;
      logic [7:0]  code_offset;
      logic [8:0]  code_total;
      logic [7:0]  symbol;
      logic        last_of_run;
   } rsp_type;

   // up to two results written to the queue in one cycle
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

   function automatic rsp_type blank_rsp(kind_type k, logic [2:0] t);
      rsp_type r;
      r = '0;
      r.kind = k;
      r.table_index = t;
      return r;
   endfunction

endpackage

/* hdl/jpeg_dht_table_builder.sv */
// top level: jpeg define-huffman-table segment parser
// the results of an item are written into the result queue when the item is accepted
// throughput: one item per cycle while each item causes at most one result and the output is not stalled
// an item causing two results (entry or symbol plus terminator or error) queues both and they leave one after the other
// the output port delivers one result per cycle while rsp_stall is low; the four-entry queue sets input stall
// synchronous active-high reset returns the parser to header state and empties the queue
`timescale 1ns / 1ps

module jpeg_dht_table_builder #(
   parameter int MAX_CODES  = jdtb_pkg::MAX_CODES_DEF,
   parameter int NUM_TABLES = jdtb_pkg::NUM_TABLES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // input item: one segment payload byte
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_seg_byte,
   input  logic        req_seg_end,
   // result item
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_kind,
   output logic [2:0]  rsp_table_index,
   output logic [7:0]  rsp_slot,
   output logic [15:0] rsp_first_code,
   output logic [15:0] rsp_end_code,
   output logic [4:0]  rsp_length_step,
   output logic [7:0]  rsp_code_offset,
   output logic [8:0]  rsp_code_total,
   output logic [7:0]  rsp_symbol,
   output logic        rsp_last_of_run
);

   jdtb_pkg::push_type push;
   jdtb_pkg::rsp_type  head;
   logic               room;
   logic               accept;

   // input is held off unless the queue can take two results
   assign req_stall = !room;
   assign accept    = req_valid && room;

   // parser: phase, running code and counts; builds up to two results per item
   jdtb_parser #(
      .MAX_CODES  (MAX_CODES),
      .NUM_TABLES (NUM_TABLES)
   ) u_parser (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .seg_byte (req_seg_byte),
      .seg_end  (req_seg_end),
      .push     (push)
   );

   // result queue decouples the two sides
   jdtb_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (head)
   );

   // unpack the queue head onto the result ports
   assign rsp_kind        = head.kind;
   assign rsp_table_index = head.table_index;
   assign rsp_slot        = head.slot;
   assign rsp_first_code  = head.first_code;
   assign rsp_end_code    = head.end_code;
   assign rsp_length_step = head.length_step;
   assign rsp_code_offset = head.code_offset;
   assign rsp_code_total  = head.code_total;
   assign rsp_symbol      = head.symbol;
   assign rsp_last_of_run = head.last_of_run;

endmodule

/* hdl/jdtb_parser.sv */
// segment byte parser: table state and result generation
`timescale 1ns / 1ps
`include "jpeg_dht_table_builder_assert.svh"

module jdtb_parser #(
   parameter int MAX_CODES  = jdtb_pkg::MAX_CODES_DEF,
   parameter int NUM_TABLES = jdtb_pkg::NUM_TABLES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         seg_byte,
   input  logic               seg_end,
   output jdtb_pkg::push_type push
);

   jdtb_pkg::phase_type phase_ff, phase_in;
   logic [2:0]  current_table_ff, current_table_in;
   logic [4:0]  count_index_ff, count_index_in;
   logic [4:0]  entry_slot_ff, entry_slot_in;
   logic [15:0] running_code_ff, running_code_in;
   logic [4:0]  length_accum_ff, length_accum_in;
   logic [11:0] symbol_sum_ff, symbol_sum_in;
   logic [8:0]  symbol_index_ff, symbol_index_in;

   jdtb_pkg::rsp_type lead, tail;
   logic        has_lead, has_tail;
   logic [3:0]  id;
   logic [4:0]  tab_full;
   logic [15:0] rc_sum;
   logic [11:0] sum_new;
   logic [4:0]  count_new;
   logic [4:0]  slot_new;
   logic [8:0]  si_new;

   always_comb begin
      phase_in         = phase_ff;
      current_table_in = current_table_ff;
      count_index_in   = count_index_ff;
      entry_slot_in    = entry_slot_ff;
      running_code_in  = running_code_ff;
      length_accum_in  = length_accum_ff;
      symbol_sum_in    = symbol_sum_ff;
      symbol_index_in  = symbol_index_ff;
      lead     = jdtb_pkg::blank_rsp(jdtb_pkg::KIND_ENTRY, current_table_ff);
      tail     = jdtb_pkg::blank_rsp(jdtb_pkg::KIND_TRUNC, current_table_ff);
      has_lead = 1'b0;
      has_tail = 1'b0;

      id        = 4'(seg_byte & jdtb_pkg::ID_MASK);
      tab_full  = {1'b0, id} + (seg_byte[jdtb_pkg::AC_BIT] ? 5'(jdtb_pkg::AC_OFFSET) : 5'd0);
      rc_sum    = running_code_ff + {8'd0, seg_byte};
      sum_new   = symbol_sum_ff + {4'd0, seg_byte};
      count_new = count_index_ff + 5'd1;
      slot_new  = entry_slot_ff + ((seg_byte != 8'd0) ? 5'd1 : 5'd0);
      si_new    = symbol_index_ff + 9'd1;

      case (phase_ff)
         jdtb_pkg::PH_HEADER: begin
            if (id >= 4'(jdtb_pkg::DC_TABLES) || tab_full >= 5'(NUM_TABLES)) begin
               tail     = jdtb_pkg::blank_rsp(jdtb_pkg::KIND_BAD_ID, 3'd0);
               has_tail = 1'b1;
               phase_in = seg_end ? jdtb_pkg::PH_HEADER : jdtb_pkg::PH_DROP;
            end else begin
               current_table_in = tab_full[2:0];
               count_index_in   = '0;
               entry_slot_in    = '0;
               running_code_in  = '0;
               length_accum_in  = 5'd1;
               symbol_sum_in    = '0;
               symbol_index_in  = '0;
               tail     = jdtb_pkg::blank_rsp(jdtb_pkg::KIND_TRUNC, tab_full[2:0]);
               has_tail = seg_end;
               phase_in = seg_end ? jdtb_pkg::PH_HEADER : jdtb_pkg::PH_COUNTS;
            end
         end
         jdtb_pkg::PH_COUNTS: begin
            if (seg_byte != 8'd0) begin
               lead.slot        = {3'd0, entry_slot_ff};
               lead.first_code  = running_code_ff;
               lead.end_code    = rc_sum;
               lead.length_step = length_accum_ff;
               lead.code_offset = symbol_sum_ff[7:0];
               has_lead         = 1'b1;
               running_code_in  = {rc_sum[14:0], 1'b0};
               length_accum_in  = 5'd1;
            end else begin
               running_code_in  = {running_code_ff[14:0], 1'b0};
               length_accum_in  = length_accum_ff + 5'd1;
            end
            entry_slot_in  = slot_new;
            symbol_sum_in  = sum_new;
            count_index_in = count_new;
            if (count_new >= 5'(jdtb_pkg::NUM_COUNTS)) begin
               has_tail = 1'b1;
               if (sum_new > 12'(MAX_CODES)) begin
                  tail.kind = jdtb_pkg::KIND_MANY;
                  phase_in  = seg_end ? jdtb_pkg::PH_HEADER : jdtb_pkg::PH_DROP;
               end else if (sum_new != 12'd0 && seg_end) begin
                  phase_in  = jdtb_pkg::PH_HEADER;
               end else begin
                  tail.kind       = jdtb_pkg::KIND_TERM;
                  tail.slot       = {3'd0, slot_new};
                  tail.code_total = sum_new[8:0];
                  symbol_index_in = '0;
                  phase_in = (sum_new == 12'd0) ? jdtb_pkg::PH_HEADER
                                                : jdtb_pkg::PH_SYMBOLS;
               end
            end else if (seg_end) begin
               has_tail = 1'b1;
               phase_in = jdtb_pkg::PH_HEADER;
            end
         end
         jdtb_pkg::PH_SYMBOLS: begin
            lead.kind       = jdtb_pkg::KIND_SYMBOL;
            lead.slot       = symbol_index_ff[7:0];
            lead.symbol     = seg_byte;
            has_lead        = 1'b1;
            symbol_index_in = si_new;
            if ({3'd0, si_new} >= symbol_sum_ff) begin
               phase_in = jdtb_pkg::PH_HEADER;
            end else if (seg_end) begin
               has_tail = 1'b1;
               phase_in = jdtb_pkg::PH_HEADER;
            end
         end
         jdtb_pkg::PH_DROP: begin
            if (seg_end) begin
               phase_in = jdtb_pkg::PH_HEADER;
            end
         end
         default: begin
            phase_in = jdtb_pkg::PH_HEADER;
         end
      endcase

      // mark the final result of this item
      tail.last_of_run = 1'b1;
      lead.last_of_run = !has_tail;

      push = '0;
      if (accept) begin
         if (has_lead) begin
            push.first  = lead;
            push.second = tail;
            push.count  = has_tail ? 2'd2 : 2'd1;
         end else begin
            push.first  = tail;
            push.second = tail;
            push.count  = has_tail ? 2'd1 : 2'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= jdtb_pkg::PH_HEADER;
         current_table_ff <= '0;
         count_index_ff   <= '0;
         entry_slot_ff    <= '0;
         running_code_ff  <= '0;
         length_accum_ff  <= 5'd1;
         symbol_sum_ff    <= '0;
         symbol_index_ff  <= '0;
      end else if (accept) begin
         phase_ff         <= phase_in;
         current_table_ff <= current_table_in;
         count_index_ff   <= count_index_in;
         entry_slot_ff    <= entry_slot_in;
         running_code_ff  <= running_code_in;
         length_accum_ff  <= length_accum_in;
         symbol_sum_ff    <= symbol_sum_in;
         symbol_index_ff  <= symbol_index_in;
      end
   end

   `JDTB_ASSERT(a_sym_total, clock, reset, (phase_ff == jdtb_pkg::PH_SYMBOLS) |-> (symbol_sum_ff != 12'd0 && symbol_sum_ff <= 12'(MAX_CODES)))
   `JDTB_ASSERT(a_count_range, clock, reset, (phase_ff == jdtb_pkg::PH_COUNTS) |-> (count_index_ff < 5'(jdtb_pkg::NUM_COUNTS)))
   `JDTB_ASSERT(a_slot_le_count, clock, reset, (phase_ff == jdtb_pkg::PH_COUNTS) |-> (entry_slot_ff <= count_index_ff))

endmodule

/* hdl/jdtb_rsp_queue.sv */
// small result queue between parser and output port
`timescale 1ns / 1ps
`include "jpeg_dht_table_builder_assert.svh"

module jdtb_rsp_queue (
   input  logic               clock,
   input  logic               reset,
   input  jdtb_pkg::push_type push,
   output logic               room,
   output logic               out_valid,
   input  logic               out_stall,
   output jdtb_pkg::rsp_type  out_data
);

   localparam int PTR_W = $clog2(jdtb_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(jdtb_pkg::QUEUE_DEPTH + 1);

   jdtb_pkg::rsp_type entry_ff [jdtb_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;
   logic [PTR_W-1:0] wr_next;

   assign out_valid = (count_ff != '0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign pop       = out_valid && !out_stall;
   // room for the two results an item can cause
   assign room      = (count_ff <= CNT_W'(jdtb_pkg::QUEUE_DEPTH - 2));
   assign wr_next   = wr_ptr_ff + PTR_W'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + (pop ? PTR_W'(1) : '0);
      count_in  = count_ff + CNT_W'(push.count) - (pop ? CNT_W'(1) : '0);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_next] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `JDTB_NEVER(a_no_overflow, clock, reset, count_ff > CNT_W'(jdtb_pkg::QUEUE_DEPTH))
   `JDTB_NEVER(a_push_when_full, clock, reset, (push.count != 2'd0) && !room)
   `JDTB_ASSERT(a_count_track, clock, reset, (push.count == 2'd2 && !pop) |=> (count_ff == $past(count_ff) + CNT_W'(2)))

endmodule
